### hdl/vertex_normal_affine_transform_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vertex / normal transform
// Clocked assertion wrappers; they compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef VERTEX_NORMAL_AFFINE_TRANSFORM_DEFINES_SVH
`define VERTEX_NORMAL_AFFINE_TRANSFORM_DEFINES_SVH

`ifndef SYNTH
// plain property, checked outside reset
`define VNAT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same-cycle implication, checked outside reset
`define VNAT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define VNAT_ASSERT(label, prop, msg)
`define VNAT_ASSERT_IMP(label, ante, cons, msg)
`endif

`endif

### hdl/vnat_pkg.sv
// ----------------------------------------------------------------------------
// vnat_pkg
// Widths, pipeline taps, register codes and types of the vertex transform.
// ----------------------------------------------------------------------------
package vnat_pkg;

  localparam int XW    = 32;          // Q16.16 component
  localparam int CW    = 16;          // Q4.12 coefficient
  localparam int PW    = XW + CW;     // one product
  localparam int SW    = 51;          // dot product plus offset
  localparam int FRAC  = 12;          // coefficient fraction bits
  localparam int RW    = SW - FRAC;   // rounded component
  localparam int AW    = RW - 1;      // magnitude
  localparam int NW    = 30;          // normalized magnitude, top bit 29
  localparam int LW    = 6;           // leading-one position
  localparam int SQW   = 2 * NW + 2;  // sum of three squares
  localparam int RTW   = SQW / 2;     // square root
  localparam int RMW   = RTW + 2;     // root remainder
  localparam int DQW   = 17;          // unit-length quotient
  localparam int QSH   = 16;          // numerator scale
  localparam int DNW   = 48;          // divider numerator
  localparam int NCOEF = 18;
  localparam int NBASE = 9;           // first normal-matrix coefficient

  // taps of the side delay line (tap 0 = shift stage)
  localparam int ROOT_TAP = 2 + RTW;
  localparam int DIV_TAP  = ROOT_TAP + DQW;
  localparam int SD_LEN   = DIV_TAP + 1;

  // out_tuser bits
  localparam int USER_ZERO = 0;
  localparam int USER_SAT  = 1;

  typedef logic [2:0][XW-1:0] vec3_t;
  typedef logic [2:0][CW-1:0] coef3_t;

  typedef enum logic [2:0] {
    REG_COEF0 = 3'd0,
    REG_COEF1 = 3'd1,
    REG_COEF2 = 3'd2,
    REG_COEF3 = 3'd3,
    REG_COEF4 = 3'd4,
    REG_TRXY  = 3'd5,
    REG_TRZ   = 3'd6,
    REG_NORM  = 3'd7
  } cfg_reg_t;

  // per-item bookkeeping carried alongside the normalize pipeline
  typedef struct packed {
    logic             valid;
    logic             norm;
    logic             zero;
    logic             sat;
    logic [2:0]       neg;
    vec3_t            clamp;
    logic [2:0][NW-1:0] a;
  } side_t;

endpackage

### hdl/vnat_lane.sv
// ----------------------------------------------------------------------------
// vnat_lane
// One output column: three products, offset add, round to Q16.16.
// ----------------------------------------------------------------------------
module vnat_lane (
  input  logic                             clk,
  input  logic                             en,
  input  vnat_pkg::vec3_t                  vec_i,
  input  vnat_pkg::coef3_t                 coef_i,
  input  logic signed [vnat_pkg::XW-1:0]   ofs_i,
  input  logic                             add_ofs_i,
  output logic signed [vnat_pkg::RW-1:0]   r_o
);
  import vnat_pkg::*;

  logic signed [PW-1:0] prod_r [3];
  logic signed [SW-1:0] ofs_r;
  logic signed [SW-1:0] sum_w;

  // stage 1: products and scaled offset
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= $signed(vec_i[i]) * $signed(coef_i[i]);
      end
      ofs_r <= add_ofs_i ? {{(SW-XW-FRAC){ofs_i[XW-1]}}, ofs_i, {FRAC{1'b0}}} : '0;
    end
  end

  // stage 2: sum, round half up, floor shift
  assign sum_w = SW'(prod_r[0]) + SW'(prod_r[1]) + SW'(prod_r[2]) + ofs_r
               + SW'(1 << (FRAC - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      r_o <= sum_w[SW-1:FRAC];
    end
  end

endmodule

### hdl/vnat_isqrt.sv
// ----------------------------------------------------------------------------
// vnat_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module vnat_isqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [vnat_pkg::SQW-1:0]    v_i,
  output logic [vnat_pkg::RTW-1:0]    root_o
);
  import vnat_pkg::*;

  logic [RMW-1:0] rem_r  [RTW-1];
  logic [SQW-1:0] rad_r  [RTW-1];
  logic [RTW-1:0] root_r [RTW];

  for (genvar s = 0; s < RTW; s++) begin : g_step
    logic [RMW-1:0] rem_in;
    logic [SQW-1:0] rad_in;
    logic [RTW-1:0] root_in;
    logic [RMW+1:0] part;
    logic [RMW+1:0] trial;
    logic           ge;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign rad_in  = v_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign rad_in  = rad_r[s-1];
      assign root_in = root_r[s-1];
    end

    // bring down two radicand bits, try root*4+1
    assign part  = {rem_in, rad_in[SQW-1 -: 2]};
    assign trial = (RMW+2)'({root_in, 2'b01});
    assign ge    = part >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[s] <= {root_in[RTW-2:0], ge};
      end
    end

    if (s < RTW - 1) begin : g_keep
      logic [RMW+1:0] diff;
      assign diff = ge ? part - trial : part;
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= diff[RMW-1:0];
          rad_r[s] <= {rad_in[SQW-3:0], 2'b00};
        end
      end
    end
  end

  assign root_o = root_r[RTW-1];

endmodule

### hdl/vnat_div.sv
// ----------------------------------------------------------------------------
// vnat_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vnat_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [vnat_pkg::DNW-1:0]    num_i,
  input  logic [vnat_pkg::RTW-1:0]    den_i,
  output logic [vnat_pkg::DQW-1:0]    q_o
);
  import vnat_pkg::*;

  logic [DNW-1:0] rem_r [DQW-1];
  logic [RTW-1:0] den_r [DQW-1];
  logic [DQW-1:0] q_r   [DQW];

  for (genvar k = 0; k < DQW; k++) begin : g_bit
    logic [DNW-1:0] rem_in;
    logic [RTW-1:0] den_in;
    logic [DQW-1:0] q_in;
    logic [DNW-1:0] dsh;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign q_in   = q_r[k-1];
    end

    // quotient bit DQW-1-k
    assign dsh = DNW'(den_in) << (DQW - 1 - k);
    assign ge  = rem_in >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k] <= {q_in[DQW-2:0], ge};
      end
    end

    if (k < DQW - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? rem_in - dsh : rem_in;
          den_r[k] <= den_in;
        end
      end
    end
  end

  assign q_o = q_r[DQW-1];

endmodule

### hdl/vertex_normal_affine_transform.sv
// Throughput: one vector per cycle; the whole pipeline advances whenever the
//   output register is empty or being taken, so a stall freezes every stage.
// Every vector runs the full normalize path (square root, divider) so order is kept.
// Reset (rst_n low, synchronous) clears all valid bits and loads identity
//   matrices, zero translation and normalizing off. No clearing pass.
// ----------------------------------------------------------------------------
// vertex_normal_affine_transform
// Point / normal transform by configured 3x3 matrices, Q16.16, with optional
// unit-length scaling of normals; three column lanes merged into one result.
// ----------------------------------------------------------------------------
`include "vertex_normal_affine_transform_defines.svh"

module vertex_normal_affine_transform (
  input  logic        clk,
  input  logic        rst_n,
  // input vectors
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // x_in [31:0], y_in [63:32], z_in [95:64]
  input  logic        in_tuser,   // vector_kind
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // x_out [31:0], y_out [63:32], z_out [95:64]
  output logic [1:0]  out_tuser,  // zero_length [0], saturated [1]
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import vnat_pkg::*;

  localparam logic signed [RW-1:0] R_MAX = {{(RW-XW+1){1'b0}}, {(XW-1){1'b1}}};
  localparam logic signed [RW-1:0] R_MIN = {{(RW-XW+1){1'b1}}, {(XW-1){1'b0}}};

  // configuration registers
  logic [63:0]   coef_bank_r [5];
  logic [63:0]   trans_xy_r;
  logic [XW-1:0] trans_z_r;
  logic          norm_en_r;

  logic          adv;
  logic [CW-1:0] coef_all [NCOEF];
  logic signed [RW-1:0] r_w [3];

  logic          s1_vld_r, s1_norm_r, s2_vld_r, s2_norm_r;
  side_t         m1_r, m1_nxt, m2_r, m2_nxt, m3_r;
  logic [AW-1:0] a1_r [3];
  logic [AW-1:0] a1_nxt [3];
  logic [AW-1:0] a2_r [3];
  logic [AW-1:0] a3_r [3];
  logic [AW-1:0] mx_r;
  logic [LW-1:0] lead_r, lead_nxt;
  side_t         sh_nxt;
  side_t         sd_r [SD_LEN];
  logic [2*NW-1:0] sq_r [3];
  logic [SQW-1:0]  sum_r;
  logic [RTW-1:0]  root_w;
  logic [DQW-1:0]  q_w [3];

  logic          out_tvalid_r;
  vec3_t         out_data_r, out_data_nxt;
  logic [1:0]    out_user_r, out_user_nxt;

  // config write port, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_bank_r[0] <= 64'd4096;
      coef_bank_r[1] <= 64'd4096;
      coef_bank_r[2] <= 64'd268439552;
      coef_bank_r[3] <= 64'd268435456;
      coef_bank_r[4] <= 64'd268435456;
      trans_xy_r     <= '0;
      trans_z_r      <= '0;
      norm_en_r      <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_COEF0: coef_bank_r[0] <= cfg_data;
        REG_COEF1: coef_bank_r[1] <= cfg_data;
        REG_COEF2: coef_bank_r[2] <= cfg_data;
        REG_COEF3: coef_bank_r[3] <= cfg_data;
        REG_COEF4: coef_bank_r[4] <= cfg_data;
        REG_TRXY:  trans_xy_r     <= cfg_data;
        REG_TRZ:   trans_z_r      <= cfg_data[XW-1:0];
        REG_NORM:  norm_en_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // unpack coefficients from the banks
  for (genvar k = 0; k < NCOEF; k++) begin : g_coef
    assign coef_all[k] = coef_bank_r[k/4][16*(k%4) +: CW];
  end

  // global advance: output slot free or being taken
  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;

  // column lanes
  for (genvar j = 0; j < 3; j++) begin : g_lane
    coef3_t               lc;
    logic signed [XW-1:0] ofs;
    for (genvar i = 0; i < 3; i++) begin : g_sel
      assign lc[i] = in_tuser ? coef_all[NBASE + 3*i + j] : coef_all[3*i + j];
    end
    if (j == 0) begin : g_x
      assign ofs = trans_xy_r[XW-1:0];
    end else if (j == 1) begin : g_y
      assign ofs = trans_xy_r[2*XW-1:XW];
    end else begin : g_z
      assign ofs = trans_z_r;
    end
    vnat_lane u_lane (
      .clk       (clk),
      .en        (adv),
      .vec_i     (in_tdata),
      .coef_i    (lc),
      .ofs_i     (ofs),
      .add_ofs_i (!in_tuser),
      .r_o       (r_w[j])
    );
  end

  // valid and mode alongside the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_tvalid;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_norm_r <= in_tuser & norm_en_r;
      s2_norm_r <= s1_norm_r;
    end
  end

  // merge 1: clamp, sign, magnitude
  always_comb begin
    logic signed [RW-1:0] mag;
    m1_nxt       = '0;
    m1_nxt.valid = s2_vld_r;
    m1_nxt.norm  = s2_norm_r;
    for (int j = 0; j < 3; j++) begin
      if (r_w[j] > R_MAX) begin
        m1_nxt.clamp[j] = R_MAX[XW-1:0];
        m1_nxt.sat      = 1'b1;
      end else if (r_w[j] < R_MIN) begin
        m1_nxt.clamp[j] = R_MIN[XW-1:0];
        m1_nxt.sat      = 1'b1;
      end else begin
        m1_nxt.clamp[j] = r_w[j][XW-1:0];
      end
      m1_nxt.neg[j] = r_w[j][RW-1];
      mag           = r_w[j][RW-1] ? -r_w[j] : r_w[j];
      a1_nxt[j]     = mag[AW-1:0];
    end
  end

  // merge 2: largest magnitude
  always_comb begin
    logic [AW-1:0] mx;
    mx = a1_r[0];
    if (a1_r[1] > mx) mx = a1_r[1];
    if (a1_r[2] > mx) mx = a1_r[2];
    m2_nxt      = m1_r;
    m2_nxt.zero = mx == '0;
  end

  // merge 3: leading-one position of the maximum
  always_comb begin
    lead_nxt = '0;
    for (int b = 0; b < AW; b++) begin
      if (mx_r[b]) lead_nxt = LW'(b);
    end
  end

  // merge 4: shift all magnitudes so the maximum tops out at bit NW-1
  always_comb begin
    logic [AW-1:0] ash;
    sh_nxt = m3_r;
    for (int j = 0; j < 3; j++) begin
      if (lead_r > LW'(NW - 1)) begin
        ash = a3_r[j] >> (lead_r - LW'(NW - 1));
      end else begin
        ash = a3_r[j] << (LW'(NW - 1) - lead_r);
      end
      sh_nxt.a[j] = ash[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_r.valid <= 1'b0;
      m2_r.valid <= 1'b0;
      m3_r.valid <= 1'b0;
    end else if (adv) begin
      m1_r <= m1_nxt;
      m2_r <= m2_nxt;
      m3_r <= m2_r;
      for (int j = 0; j < 3; j++) begin
        a1_r[j] <= a1_nxt[j];
        a2_r[j] <= a1_r[j];
        a3_r[j] <= a2_r[j];
      end
      mx_r   <= a1_r[0] > a1_r[1] ? (a1_r[0] > a1_r[2] ? a1_r[0] : a1_r[2])
                                  : (a1_r[1] > a1_r[2] ? a1_r[1] : a1_r[2]);
      lead_r <= lead_nxt;
    end
  end

  // side delay line over squares, root and divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SD_LEN; k++) sd_r[k] <= '0;
    end else if (adv) begin
      sd_r[0] <= sh_nxt;
      for (int k = 1; k < SD_LEN; k++) sd_r[k] <= sd_r[k-1];
    end
  end

  // squares, then their sum
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        sq_r[j] <= sd_r[0].a[j] * sd_r[0].a[j];
      end
      sum_r <= SQW'(sq_r[0]) + SQW'(sq_r[1]) + SQW'(sq_r[2]);
    end
  end

  vnat_isqrt u_isqrt (
    .clk    (clk),
    .en     (adv),
    .v_i    (sum_r),
    .root_o (root_w)
  );

  // per-component rounded quotient
  for (genvar j = 0; j < 3; j++) begin : g_div
    logic [DNW-1:0] num;
    assign num = DNW'({sd_r[ROOT_TAP].a[j], {QSH{1'b0}}}) + DNW'(root_w[RTW-1:1]);
    vnat_div u_div (
      .clk   (clk),
      .en    (adv),
      .num_i (num),
      .den_i (root_w),
      .q_o   (q_w[j])
    );
  end

  // output select
  always_comb begin
    out_data_nxt = sd_r[DIV_TAP].clamp;
    out_user_nxt = '0;
    out_user_nxt[USER_SAT] = sd_r[DIV_TAP].sat;
    if (sd_r[DIV_TAP].norm) begin
      out_user_nxt[USER_SAT] = 1'b0;
      if (sd_r[DIV_TAP].zero) begin
        out_data_nxt            = '0;
        out_user_nxt[USER_ZERO] = 1'b1;
      end else begin
        for (int j = 0; j < 3; j++) begin
          out_data_nxt[j] = sd_r[DIV_TAP].neg[j] ? -XW'(q_w[j]) : XW'(q_w[j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= sd_r[DIV_TAP].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // checks
  `VNAT_ASSERT_IMP(a_zero_data, out_tvalid && out_tuser[USER_ZERO], out_tdata == '0, "zero-length result carries nonzero data")
  `VNAT_ASSERT(a_flag_excl, !(out_tvalid && out_tuser[USER_ZERO] && out_tuser[USER_SAT]), "zero-length and saturated flags together")
  `VNAT_ASSERT_IMP(a_root_range, sd_r[ROOT_TAP].valid && sd_r[ROOT_TAP].norm && !sd_r[ROOT_TAP].zero, root_w[RTW-1:RTW-2] != 2'b00, "root of normalized vector below range")
  `VNAT_ASSERT_IMP(a_unit_mag, sd_r[DIV_TAP].valid && sd_r[DIV_TAP].norm && !sd_r[DIV_TAP].zero, q_w[0] <= DQW'(1 << QSH) && q_w[1] <= DQW'(1 << QSH) && q_w[2] <= DQW'(1 << QSH), "unit component above one")

endmodule

### sim/tb_vertex_normal_affine_transform.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vertex_normal_affine_transform
// Self-checking bench for the point / normal transform. Drives vectors on the
// input stream under random idling, predicts every result in a scoreboard
// (matrix product, rounding, clamping, unit-length scaling) and compares it
// field by field with each output beat. Registers are rewritten between
// phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_vertex_normal_affine_transform;
  import vnat_pkg::*;

  localparam int DRAIN_CYCLES = 80;
  localparam longint LIMIT    = 400000;
  localparam logic KIND_POINT  = 1'b0;
  localparam logic KIND_NORMAL = 1'b1;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        zero;
    logic        sat;
  } xform_res_t;

  // --------------------------------------------------------------------------
  // scoreboard: own register copy, transform predictor, expected queue
  // --------------------------------------------------------------------------
  class xform_board;
    logic [63:0] bank[5];
    logic [63:0] tr_xy;
    logic [31:0] tr_z;
    logic        norm_on;
    xform_res_t  pending[$];
    int          mismatches;

    function new();
      bank[0] = 64'd4096; bank[1] = 64'd4096; bank[2] = 64'd268439552;
      bank[3] = 64'd268435456; bank[4] = 64'd268435456;
      tr_xy = '0; tr_z = '0; norm_on = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [63:0] val);
      case (idx)
        REG_TRXY: tr_xy = val;
        REG_TRZ:  tr_z = val[31:0];
        REG_NORM: norm_on = val[0];
        default:  bank[idx] = val;
      endcase
    endfunction

    function longint coefficient(int k);
      logic [15:0] c;
      c = bank[k / 4][16 * (k % 4) +: 16];
      return longint'($signed(c));
    endfunction

    function longint unsigned root64(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // note an accepted input beat
    function void note_vector(logic kind, logic [31:0] x, logic [31:0] y, logic [31:0] z);
      longint v[3], r[3], tr[3], acc, q;
      longint unsigned a[3], mx, sum, m;
      xform_res_t e;
      int base;
      v[0] = $signed(x); v[1] = $signed(y); v[2] = $signed(z);
      tr[0] = $signed(tr_xy[31:0]); tr[1] = $signed(tr_xy[63:32]); tr[2] = $signed(tr_z);
      base = kind ? NBASE : 0;
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int i = 0; i < 3; i++) acc += v[i] * coefficient(base + 3 * i + j);
        if (!kind) acc += tr[j] * 4096;
        r[j] = (acc + 2048) >>> 12;
      end
      e.zero = 1'b0; e.sat = 1'b0;
      if (kind && norm_on) begin
        for (int j = 0; j < 3; j++) a[j] = r[j] < 0 ? -r[j] : r[j];
        mx = a[0];
        if (a[1] > mx) mx = a[1];
        if (a[2] > mx) mx = a[2];
        if (mx == 0) begin
          e.zero = 1'b1;
          r[0] = 0; r[1] = 0; r[2] = 0;
        end else begin
          while (mx >= (64'd1 << 30)) begin
            mx >>= 1;
            for (int j = 0; j < 3; j++) a[j] >>= 1;
          end
          while (mx < (64'd1 << 29)) begin
            mx <<= 1;
            for (int j = 0; j < 3; j++) a[j] <<= 1;
          end
          sum = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
          m = root64(sum);
          for (int j = 0; j < 3; j++) begin
            q = longint'((a[j] * 65536 + (m >> 1)) / m);
            r[j] = r[j] < 0 ? -q : q;
          end
        end
      end else begin
        for (int j = 0; j < 3; j++) begin
          if (r[j] > 64'sd2147483647) begin
            r[j] = 64'sd2147483647; e.sat = 1'b1;
          end else if (r[j] < -64'sd2147483648) begin
            r[j] = -64'sd2147483648; e.sat = 1'b1;
          end
        end
      end
      e.x = r[0][31:0]; e.y = r[1][31:0]; e.z = r[2][31:0];
      pending.push_back(e);
    endfunction

    // check one output beat against the oldest expectation
    function void check_result(logic [95:0] data, logic [1:0] user);
      xform_res_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: data %h user %b", data, user);
        return;
      end
      e = pending.pop_front();
      if (data[31:0] !== e.x || data[63:32] !== e.y || data[95:64] !== e.z
          || user[USER_ZERO] !== e.zero || user[USER_SAT] !== e.sat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: exp x %h y %h z %h zero %b sat %b, got x %h y %h z %h user %b",
                   e.x, e.y, e.z, e.zero, e.sat,
                   data[31:0], data[63:32], data[95:64], user);
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, in_tuser;
  logic [95:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [95:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  xform_board board;
  int  src_idle_pct, sink_idle_pct;
  bit  hold_off;
  longint cycles;

  vertex_normal_affine_transform dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("vertex_normal_affine_transform verification failed");
        $finish;
      end
    end
  end

  // receiver: random stall plus an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) board.check_result(out_tdata, out_tuser);
      out_tready <= !hold_off && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // one register write, then cfg_valid dropped before the task returns
  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one input beat, with random idle cycles ahead of it
  task automatic send_vector(logic kind, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {z, y, x};
    do @(posedge clk); while (!in_tready);
    board.note_vector(kind, x, y, z);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return 32'h8000_0000 | $urandom_range(3);
      1: return 32'h7FFF_FFFF - $urandom_range(3);
      2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      3: return $urandom_range(3) - 1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [63:0] rand_bank();
    logic [63:0] b;
    for (int k = 0; k < 4; k++)
      case ($urandom_range(3))
        0: b[16*k +: 16] = $urandom();
        1: b[16*k +: 16] = 16'h1000;
        2: b[16*k +: 16] = $urandom_range(0, 16'h2000) - 16'h1000;
        default: b[16*k +: 16] = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      endcase
    return b;
  endfunction

  task automatic random_vectors(int n);
    for (int i = 0; i < n; i++)
      send_vector(1'($urandom_range(1)), rand_comp(), rand_comp(), rand_comp());
  endtask

  task automatic random_setting(bit extreme);
    for (int i = 0; i < 5; i++)
      write_reg(cfg_reg_t'(i), extreme ? {4{16'h8000}} | (i[0] ? 64'h7FFF : 64'h0) : rand_bank());
    write_reg(REG_TRXY, extreme ? 64'h8000_0000_7FFF_FFFF : {$urandom(), $urandom()});
    write_reg(REG_TRZ, extreme ? 64'hFFFF_FFFF_8000_0000 : {32'h0, rand_comp()});
    write_reg(REG_NORM, 64'($urandom_range(1)));
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tuser = 1'b0; in_tdata = '0;
    cfg_valid = 1'b0; cfg_index = REG_COEF0; cfg_data = '0;
    out_tready = 1'b0;
    hold_off = 1'b0;
    src_idle_pct = 0; sink_idle_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: identity matrices, extremes, both kinds
    send_vector(KIND_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    send_vector(KIND_NORMAL, 32'h0001_0000, 32'hFFFF_0000, 32'h0);
    drain();
    // translation pushes points past both rails
    write_reg(REG_TRXY, 64'h8000_0000_7FFF_FFFF);
    write_reg(REG_TRZ, 64'h0000_0000_0001_0000);
    send_vector(KIND_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_vector(KIND_POINT, 32'h0, 32'h0, 32'h0);
    send_vector(KIND_NORMAL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1);
    drain();
    // normalizing: zero-length, tiny, huge and rounding-half cases
    write_reg(REG_NORM, 64'd1);
    send_vector(KIND_NORMAL, 32'h0, 32'h0, 32'h0);
    send_vector(KIND_NORMAL, 32'h1, 32'h0, 32'h0);
    send_vector(KIND_NORMAL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vector(KIND_NORMAL, 32'h0003_0000, 32'hFFFC_0000, 32'h0);
    send_vector(KIND_POINT, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    drain();
    // extreme coefficients: products overflow the Q16.16 output range
    for (int i = 0; i < 5; i++) write_reg(cfg_reg_t'(i), {4{16'h8000}});
    send_vector(KIND_POINT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vector(KIND_NORMAL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_vector(KIND_NORMAL, 32'h0000_0800, 32'h0, 32'h0);
    drain();
    write_reg(REG_NORM, 64'd0);
    send_vector(KIND_NORMAL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vector(KIND_POINT, 32'h0000_0800, 32'hFFFF_F800, 32'h1);
    drain();

    // random phases with changing idle shapes
    src_idle_pct = 22; sink_idle_pct = 47;
    random_setting(1'b0); random_vectors(150); drain();
    random_setting(1'b1); random_vectors(100); drain();
    src_idle_pct = 47; sink_idle_pct = 22;
    random_setting(1'b0); random_vectors(150); drain();
    random_setting(1'b0); random_vectors(100); drain();
    src_idle_pct = 0; sink_idle_pct = 0;
    random_setting(1'b0);
    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      random_vectors(150);
    join
    drain();
    random_setting(1'b0); random_vectors(150); drain();
    random_setting(1'b1); random_vectors(135); drain();

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("vertex_normal_affine_transform verification clean");
    end else begin
      $display("vertex_normal_affine_transform verification failed");
    end
    $finish;
  end
endmodule
